@@ hw/rtl/assert_macros.svh @@
// assert_macros.svh: assertion macros used by the top level.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check, sampled on the rising clock edge, off during reset
`define MBR_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Implication check: cons must hold in any cycle where ante holds
`define MBR_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/mbr_pkg.sv @@
// mbr_pkg: constants and types for the MBR partition table parser.
// Used by mbr_front, mbr_job_queue, mbr_back and the top level.
package mbr_pkg;

    // Sector layout
    localparam logic [8:0] TABLE_OFFSET = 9'd446;
    localparam logic [8:0] TABLE_END    = 9'd510;
    localparam logic [8:0] SIG_POS0     = 9'd510;
    localparam logic [8:0] SIG_POS1     = 9'd511;
    localparam logic [7:0] SIG_FIRST    = 8'h55;
    localparam logic [7:0] SIG_SECOND   = 8'hAA;

    // Table storage: 16 little-endian words, four per entry
    localparam int TBL_WORDS = 16;
    localparam int TBL_AW    = 4;

    // Word index inside one 16-byte entry
    localparam logic [1:0] WORD_TYPE  = 2'd1;
    localparam logic [1:0] WORD_START = 2'd2;
    localparam logic [1:0] WORD_LEN   = 2'd3;

    // Job queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Table word write from the front
    typedef struct packed {
        logic              we;
        logic [TBL_AW-1:0] addr;
        logic [31:0]       data;
    } tbl_wr_t;

    // Request pushed at the end of a sector
    typedef struct packed {
        logic push;
        logic sig_ok;
    } job_push_t;

    // Queue status seen by front and back
    typedef struct packed {
        logic empty;
        logic full;
        logic head_sig_ok;
    } q_stat_t;

    // One result item
    typedef struct packed {
        logic        signature_ok;
        logic        entry_valid;
        logic [2:0]  part_number;
        logic [1:0]  table_slot;
        logic [7:0]  part_type;
        logic [31:0] start_sector;
        logic [31:0] sector_count;
        logic        last;
    } result_t;

endpackage

@@ hw/rtl/mbr_front.sv @@
// mbr_front: byte counter, table word assembly and signature check.
// Depends on mbr_pkg; feeds the table memory in mbr_back and mbr_job_queue.
module mbr_front
    import mbr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  logic [7:0] data_byte,
    input  logic      sector_start,
    input  q_stat_t   q_stat,
    output logic      busy,
    output tbl_wr_t   tbl_wr,
    output job_push_t job_push
);

    logic [8:0]  byte_count_reg, byte_count_next;
    logic        first_sig_reg, first_sig_next;
    logic [23:0] shift_reg, shift_next;

    logic        accept;
    logic [8:0]  pos;
    logic [8:0]  tbl_off;
    logic        in_table;

    assign busy   = q_stat.full;
    assign accept = start && !q_stat.full;

    // Byte position and table offset of the incoming byte
    assign pos      = sector_start ? 9'd0 : byte_count_reg;
    assign tbl_off  = pos - TABLE_OFFSET;
    assign in_table = (pos >= TABLE_OFFSET) && (pos < TABLE_END);

    // Next-state logic
    always_comb
    begin
        byte_count_next = byte_count_reg;
        first_sig_next  = first_sig_reg;
        shift_next      = shift_reg;
        tbl_wr.we       = 1'b0;
        tbl_wr.addr     = tbl_off[5:2];
        tbl_wr.data     = {data_byte, shift_reg};
        job_push.push   = 1'b0;
        job_push.sig_ok = first_sig_reg && (data_byte == SIG_SECOND);
        if (accept)
        begin
            byte_count_next = pos + 9'd1;
            if (in_table)
            begin
                // gather little-endian bytes, write on the fourth
                shift_next = {data_byte, shift_reg[23:8]};
                tbl_wr.we  = (tbl_off[1:0] == 2'd3);
            end
            else if (pos == SIG_POS0)
            begin
                first_sig_next = (data_byte == SIG_FIRST);
            end
            else if (pos == SIG_POS1)
            begin
                job_push.push = 1'b1;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= 9'd0;
            first_sig_reg  <= 1'b0;
        end
        else
        begin
            byte_count_reg <= byte_count_next;
            first_sig_reg  <= first_sig_next;
        end
    end

    // Byte gather register, no reset needed
    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
    end

endmodule

@@ hw/rtl/mbr_job_queue.sv @@
// mbr_job_queue: two-entry FIFO of end-of-sector requests.
// Depends on mbr_pkg; sits between mbr_front and mbr_back.
module mbr_job_queue
    import mbr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  job_push_t job_push,
    input  logic      pop,
    output q_stat_t   q_stat
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [QUEUE_DEPTH-1:0] sig_reg;
    logic [PW-1:0]          wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]          rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]          count_reg, count_next;
    logic                   do_push, do_pop;

    assign q_stat.empty       = (count_reg == CW'(0));
    assign q_stat.full        = (count_reg == CW'(QUEUE_DEPTH));
    assign q_stat.head_sig_ok = sig_reg[rd_ptr_reg];

    assign do_push = job_push.push && !q_stat.full;
    assign do_pop  = pop && !q_stat.empty;

    // Pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? PW'(0) : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? PW'(0) : rd_ptr_reg + PW'(1);
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + CW'(1);
            2'b01:   count_next = count_reg - CW'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            sig_reg[wr_ptr_reg] <= job_push.sig_ok;
        end
    end

endmodule

@@ hw/rtl/mbr_back.sv @@
// mbr_back: table memory and the sequencer that walks the four entries.
// Depends on mbr_pkg; takes requests from mbr_job_queue, writes from mbr_front.
module mbr_back
    import mbr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  tbl_wr_t tbl_wr,
    input  q_stat_t q_stat,
    output logic    pop,
    output logic    result_strobe,
    output result_t result
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_FETCH = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    logic [31:0]       tbl_mem [TBL_WORDS];
    logic [31:0]       rd_data_reg;
    logic [TBL_AW-1:0] rd_addr;

    logic [1:0]  state_reg, state_next;
    logic [1:0]  slot_reg, slot_next;
    logic [1:0]  step_reg, step_next;
    logic [2:0]  found_reg, found_next;
    logic        pend_valid_reg, pend_valid_next;
    logic        strobe_reg, strobe_next;
    logic [7:0]  type_reg, type_next;
    logic [31:0] start_reg, start_next;
    result_t     pend_reg, pend_next;
    result_t     out_reg, out_next;
    result_t     status_res;
    result_t     entry_res;
    logic        usable;

    assign result_strobe = strobe_reg;
    assign result        = out_reg;

    // Word address: step 0,1,2 fetch type, start and length words of the slot
    assign rd_addr = {slot_reg, step_reg + 2'd1};

    // Table memory: one write port from the front, one registered read port
    always_ff @(posedge clk)
    begin
        if (tbl_wr.we)
        begin
            tbl_mem[tbl_wr.addr] <= tbl_wr.data;
        end
        rd_data_reg <= tbl_mem[rd_addr];
    end

    // Candidate result once the length word is in
    assign usable = (type_reg != 8'd0) && (rd_data_reg != 32'd0);

    always_comb
    begin
        entry_res              = '0;
        entry_res.signature_ok = 1'b1;
        entry_res.entry_valid  = 1'b1;
        entry_res.part_number  = found_reg + 3'd1;
        entry_res.table_slot   = slot_reg;
        entry_res.part_type    = type_reg;
        entry_res.start_sector = start_reg;
        entry_res.sector_count = rd_data_reg;
        entry_res.last         = 1'b0;
    end

    // Sequencer; one usable entry is held back so the final one can carry last
    always_comb
    begin
        state_next      = state_reg;
        slot_next       = slot_reg;
        step_next       = step_reg;
        found_next      = found_reg;
        pend_valid_next = pend_valid_reg;
        strobe_next     = 1'b0;
        type_next       = type_reg;
        start_next      = start_reg;
        pend_next       = pend_reg;
        out_next        = out_reg;
        pop             = 1'b0;
        status_res      = '0;
        status_res.last = 1'b1;

        case (state_reg)
            ST_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    pop = 1'b1;
                    if (q_stat.head_sig_ok)
                    begin
                        slot_next       = 2'd0;
                        step_next       = 2'd0;
                        found_next      = 3'd0;
                        pend_valid_next = 1'b0;
                        state_next      = ST_FETCH;
                    end
                    else
                    begin
                        // bad signature: lone status result
                        out_next    = status_res;
                        strobe_next = 1'b1;
                    end
                end
            end
            ST_FETCH:
            begin
                step_next = step_reg + 2'd1;
                if (step_reg == WORD_TYPE)
                begin
                    type_next = rd_data_reg[7:0];
                end
                else if (step_reg == WORD_START)
                begin
                    start_next = rd_data_reg;
                end
                else if (step_reg == WORD_LEN)
                begin
                    if (usable)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_next    = pend_reg;
                            strobe_next = 1'b1;
                        end
                        pend_next       = entry_res;
                        pend_valid_next = 1'b1;
                        found_next      = found_reg + 3'd1;
                    end
                    if (slot_reg == 2'd3)
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        slot_next = slot_reg + 2'd1;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (pend_valid_reg)
                begin
                    out_next      = pend_reg;
                    out_next.last = 1'b1;
                end
                else
                begin
                    // good signature but nothing usable
                    out_next              = status_res;
                    out_next.signature_ok = 1'b1;
                end
                strobe_next     = 1'b1;
                pend_valid_next = 1'b0;
                state_next      = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            slot_reg       <= 2'd0;
            step_reg       <= 2'd0;
            found_reg      <= 3'd0;
            pend_valid_reg <= 1'b0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            slot_reg       <= slot_next;
            step_reg       <= step_next;
            found_reg      <= found_next;
            pend_valid_reg <= pend_valid_next;
            strobe_reg     <= strobe_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        type_reg  <= type_next;
        start_reg <= start_next;
        pend_reg  <= pend_next;
        out_reg   <= out_next;
    end

endmodule

@@ hw/rtl/mbr_partition_table_parser.sv @@
// Top level of the MBR partition table parser: front, job queue and back.
// Depends on mbr_pkg, mbr_front, mbr_job_queue, mbr_back and assert_macros.svh.
//
// One sector byte is taken per cycle (start high, busy low). The front
// counts bytes, packs the table bytes at offsets 446..509 into sixteen
// 32-bit words and checks the 0x55 0xAA signature; on byte 511 it queues a
// request. The back walks the four entries over the table memory's single
// registered read port, fetching the type, start and length words of each
// entry in turn. Results appear one per cycle at most, each for one cycle
// with result_strobe high; they cannot be held off. busy rises only when
// the two-entry request queue is full, which a stream of 512-byte sectors
// never causes.
`include "assert_macros.svh"

module mbr_partition_table_parser
    import mbr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [7:0]  data_byte,
    input  logic        sector_start,
    output logic        result_strobe,
    output logic        signature_ok,
    output logic        entry_valid,
    output logic [2:0]  part_number,
    output logic [1:0]  table_slot,
    output logic [7:0]  part_type,
    output logic [31:0] start_sector,
    output logic [31:0] sector_count,
    output logic        last
);

    tbl_wr_t   tbl_wr;
    job_push_t job_push;
    q_stat_t   q_stat;
    logic      pop;
    result_t   result;

    mbr_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .data_byte    (data_byte),
        .sector_start (sector_start),
        .q_stat       (q_stat),
        .busy         (busy),
        .tbl_wr       (tbl_wr),
        .job_push     (job_push)
    );

    mbr_job_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .job_push (job_push),
        .pop      (pop),
        .q_stat   (q_stat)
    );

    mbr_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .tbl_wr        (tbl_wr),
        .q_stat        (q_stat),
        .pop           (pop),
        .result_strobe (result_strobe),
        .result        (result)
    );

    assign signature_ok = result.signature_ok;
    assign entry_valid  = result.entry_valid;
    assign part_number  = result.part_number;
    assign table_slot   = result.table_slot;
    assign part_type    = result.part_type;
    assign start_sector = result.start_sector;
    assign sector_count = result.sector_count;
    assign last         = result.last;

    // Checks
    `MBR_ASSERT_IMPL(a_no_push_when_full, clk, rst_n, job_push.push, !q_stat.full,
        "request pushed into a full queue")
    `MBR_ASSERT_IMPL(a_entry_needs_sig, clk, rst_n, result_strobe && entry_valid,
        signature_ok, "partition result without a good signature")
    `MBR_ASSERT_IMPL(a_status_is_last, clk, rst_n, result_strobe && !entry_valid,
        last && (part_number == 3'd0), "status result not final or numbered")
    `MBR_ASSERT(a_number_matches_valid, clk, rst_n,
        !result_strobe || (entry_valid == (part_number != 3'd0)), "part number mismatch")

endmodule
